FILE: hw/rtl/swmm_pkg.sv
package swmm_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int WS_W           = 7;
	localparam int WINDOW_MAX_DEF = 64;
	localparam logic [WS_W-1:0] WS_RESET = 7'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} sample_req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] window_min;
		logic signed [SAMPLE_W-1:0] window_max;
	} result_t;

	// Partial result that travels down the row of cells.
	// While rem is nonzero, each cell folds its sample in and counts rem down.
	typedef struct packed {
		logic                       act;
		logic [WS_W-1:0]            rem;
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
	} token_t;

endpackage

FILE: hw/rtl/swmm_cell.sv
module swmm_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 shift_en,
	input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample_in,
	input  swmm_pkg::token_t                     tok_in,
	output logic signed [swmm_pkg::SAMPLE_W-1:0] sample_q,
	output swmm_pkg::token_t                     tok_q
);

	swmm_pkg::token_t tok_next;

	always_comb begin
		tok_next = tok_in;
		if (tok_in.rem != '0) begin
			tok_next.rem = tok_in.rem - 1'b1;
			if (sample_q < tok_in.lo) begin
				tok_next.lo = sample_q;
			end
			if (sample_q > tok_in.hi) begin
				tok_next.hi = sample_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
		end
	end

endmodule

FILE: hw/rtl/sliding_window_min_max.sv
// Sliding-window minimum and maximum over a row of WINDOW_MAX cells.
// A request that yields a result shows it once the partial result has walked
// the whole row, from the inject register through each cell's token register to
// the result register; the block then takes no request until that result is taken.
// A request that yields no result leaves the block ready in the next cycle.
// Reset clears the fill count, the window size to 3 and all valid flags.
module sliding_window_min_max #(
	parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swmm_pkg::WS_W-1:0]     cfg_wdata,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  swmm_pkg::sample_req_t         sample_req,
	output logic                          result_valid,
	input  logic                          result_stall,
	output swmm_pkg::result_t             result
);

	localparam int FC_W  = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = ((FC_W > swmm_pkg::WS_W) ? FC_W : swmm_pkg::WS_W) + 1;

	logic [swmm_pkg::WS_W-1:0] ws_q;
	logic [FC_W-1:0]           filled_q;
	logic [FC_W-1:0]           filled_next;
	logic [CMP_W-1:0]          ws_ext;
	logic [CMP_W-1:0]          eff_w;
	logic                      busy_q;
	logic                      accept;
	logic                      fires;
	swmm_pkg::token_t          inject_s1;
	swmm_pkg::result_t         result_q;
	logic                      result_valid_q;

	logic signed [swmm_pkg::SAMPLE_W-1:0] samp [WINDOW_MAX];
	swmm_pkg::token_t                     tok  [WINDOW_MAX+1];

	assign accept       = sample_valid && !busy_q;
	assign sample_stall = busy_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		ws_ext = CMP_W'(ws_q);
		if (ws_ext == '0) begin
			eff_w = CMP_W'(1);
		end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
			eff_w = CMP_W'(WINDOW_MAX);
		end else begin
			eff_w = ws_ext;
		end

		if (sample_req.restart) begin
			filled_next = FC_W'(1);
		end else if (filled_q == FC_W'(WINDOW_MAX)) begin
			filled_next = filled_q;
		end else begin
			filled_next = filled_q + 1'b1;
		end

		fires = CMP_W'(filled_next) >= eff_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q           <= swmm_pkg::WS_RESET;
			filled_q       <= '0;
			busy_q         <= 1'b0;
			inject_s1      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
			end
			inject_s1.act <= accept && fires;
			if (accept) begin
				filled_q      <= filled_next;
				busy_q        <= fires;
				inject_s1.rem <= eff_w[swmm_pkg::WS_W-1:0];
				inject_s1.lo  <= sample_req.sample;
				inject_s1.hi  <= sample_req.sample;
			end else if (result_valid_q && !result_stall) begin
				busy_q <= 1'b0;
			end
			if (tok[WINDOW_MAX].act) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[WINDOW_MAX].act) begin
			result_q.window_min <= tok[WINDOW_MAX].lo;
			result_q.window_max <= tok[WINDOW_MAX].hi;
		end
	end

	assign tok[0] = inject_s1;

	// The newest sample sits in cell 0; older samples move one cell on per request.
	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		logic signed [swmm_pkg::SAMPLE_W-1:0] s_in;
		if (k == 0) begin : g_head
			assign s_in = sample_req.sample;
		end else begin : g_body
			assign s_in = samp[k-1];
		end
		swmm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (accept),
			.sample_in (s_in),
			.tok_in    (tok[k]),
			.sample_q  (samp[k]),
			.tok_q     (tok[k+1])
		);
	end

endmodule

FILE: sim/tb_sliding_window_min_max.sv
`timescale 1ns / 1ps

module tb_sliding_window_min_max;

	localparam int WIN_MAX    = swmm_pkg::WINDOW_MAX_DEF;
	localparam int LONG_HOLD  = 400;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES     = 26;
	localparam int PHASE_LEN  = 65;

	// Tracks the sample history of the current sequence and predicts the
	// minimum and maximum that each accepted request should produce.
	class window_tracker;
		logic signed [swmm_pkg::SAMPLE_W-1:0] history [WIN_MAX];
		int unsigned                          fill;
		int unsigned                          wpos;
		logic [swmm_pkg::WS_W-1:0]            wsize;
		swmm_pkg::result_t                    pending[$];
		int                                   errors;

		function new();
			for (int i = 0; i < WIN_MAX; i++) history[i] = '0;
			fill   = 0;
			wpos   = 0;
			wsize  = swmm_pkg::WS_RESET;
			errors = 0;
		endfunction

		function void set_window(logic [swmm_pkg::WS_W-1:0] v);
			wsize = v;
		endfunction

		function int unsigned span();
			if (wsize == 0) return 1;
			if (wsize > WIN_MAX) return WIN_MAX;
			return wsize;
		endfunction

		function void take_sample(swmm_pkg::sample_req_t r);
			int unsigned                          w;
			int unsigned                          pos;
			logic signed [swmm_pkg::SAMPLE_W-1:0] lo;
			logic signed [swmm_pkg::SAMPLE_W-1:0] hi;
			swmm_pkg::result_t                    res;
			if (r.restart) begin
				fill = 0;
				wpos = 0;
			end
			history[wpos] = r.sample;
			wpos = (wpos + 1) % WIN_MAX;
			if (fill < WIN_MAX) fill++;
			w = span();
			if (fill < w) return;
			lo  = r.sample;
			hi  = r.sample;
			pos = wpos;
			for (int i = 0; i < w; i++) begin
				pos = (pos == 0) ? WIN_MAX - 1 : pos - 1;
				if (history[pos] < lo) lo = history[pos];
				if (history[pos] > hi) hi = history[pos];
			end
			res.window_min = lo;
			res.window_max = hi;
			pending.push_back(res);
		endfunction

		function void check_extremes(swmm_pkg::result_t got);
			swmm_pkg::result_t want;
			if (pending.size() == 0) begin
				$error("result with nothing pending: window_min %0d window_max %0d",
					got.window_min, got.window_max);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.window_min !== want.window_min) begin
				$error("window_min: expected %0d, actual %0d", want.window_min, got.window_min);
				errors++;
			end
			if (got.window_max !== want.window_max) begin
				$error("window_max: expected %0d, actual %0d", want.window_max, got.window_max);
				errors++;
			end
		endfunction
	endclass

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_we       = 1'b0;
	logic [swmm_pkg::WS_W-1:0] cfg_wdata    = '0;
	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	swmm_pkg::sample_req_t     sample_req   = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	swmm_pkg::result_t         result;

	window_tracker tracker;
	bit            sender_quiet   = 1'b0;
	bit            receiver_quiet = 1'b0;
	bit            long_hold      = 1'b0;
	int            idle_cycles    = 0;

	sliding_window_min_max DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_req   (sample_req),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Ends the run if neither channel moves a request for too long.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [swmm_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 16)) - 32'd8;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_sample(input swmm_pkg::sample_req_t r);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_req   <= r;
		do @(posedge clk); while (sample_stall);
		tracker.take_sample(r);
	endtask

	task automatic send_value(input bit rs, input logic [swmm_pkg::SAMPLE_W-1:0] v);
		swmm_pkg::sample_req_t r;
		r.restart = rs;
		r.sample  = v;
		send_sample(r);
	endtask

	// Mostly whole sequences long enough to fill the window, with some short
	// ones and the odd stray restart that breaks a sequence.
	task automatic feed_samples(input int count, input bit keep_history);
		int                    seq_left;
		int unsigned           w;
		bit                    restart_now;
		swmm_pkg::sample_req_t r;
		seq_left    = 0;
		restart_now = 1'b0;
		w           = tracker.span();
		for (int k = 0; k < count; k++) begin
			if (seq_left == 0) begin
				seq_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w)
					: w + $urandom_range(0, 40);
				restart_now = !(k == 0 && keep_history);
			end
			if ($urandom_range(0, 24) == 0) restart_now = 1'b1;
			r.sample  = pick_sample();
			r.restart = restart_now;
			send_sample(r);
			seq_left--;
			restart_now = 1'b0;
		end
	endtask

	// Waits until every pending result has been taken and the block has had
	// time to finish any request that produces no result.
	task automatic settle();
		sample_valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (WIN_MAX + 4) @(posedge clk);
	endtask

	task automatic write_window(input logic [swmm_pkg::WS_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_window(v);
	endtask

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = long_hold ? LONG_HOLD : (receiver_quiet ? 0 : $urandom_range(0, 14));
			long_hold = 1'b0;
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
			tracker.check_extremes(result);
		end
	end

	initial begin
		int preset_windows [9];
		int w;
		preset_windows = '{64, 127, 65, 100, 2, 0, 1, 63, 33};
		tracker = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The window starts at its reset size of three.
		send_value(1'b1, 32'h7FFF_FFFF);
		send_value(1'b0, 32'h8000_0000);
		send_value(1'b0, 32'h0000_0000);
		send_value(1'b0, 32'hFFFF_FFFF);
		send_value(1'b0, 32'h0000_0001);
		send_value(1'b1, 32'h0000_0005);
		send_value(1'b0, 32'h0000_0007);
		send_value(1'b0, 32'hFFFF_FFF9);
		settle();
		// A zero window behaves as a window of one.
		write_window('0);
		send_value(1'b1, 32'h8000_0000);
		send_value(1'b0, 32'h7FFF_FFFF);
		send_value(1'b0, 32'hFFFF_FFFE);
		settle();
		// Growing the window mid-sequence keeps the history.
		write_window(7'd2);
		send_value(1'b0, 32'h0000_0009);
		send_value(1'b0, 32'hFFFF_FFF7);
		send_value(1'b0, 32'h5555_5555);
		send_value(1'b0, 32'hAAAA_AAAA);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph < 9)
				w = preset_windows[ph];
			else if ($urandom_range(0, 9) < 7)
				w = $urandom_range(1, 8);
			else if ($urandom_range(0, 2) != 0)
				w = $urandom_range(9, WIN_MAX);
			else
				w = $urandom_range(0, 127);
			write_window(w[swmm_pkg::WS_W-1:0]);
			if (ph == 4) begin
				// Receiver holds off while the sender keeps offering requests.
				long_hold      = 1'b1;
				sender_quiet   = 1'b1;
				receiver_quiet = 1'b0;
			end else begin
				sender_quiet   = ($urandom_range(0, 3) == 0);
				receiver_quiet = ($urandom_range(0, 3) == 0);
			end
			feed_samples(PHASE_LEN, ph[0]);
		end

		settle();
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
